// File: sv/drt_pkg.sv
// Shared types, codes and constants of the damage rectangle tracker.
package drt_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int DIM_W           = 14;
    localparam int COORD_W         = 13;
    localparam int PEND_W          = 5;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam logic [DIM_W-1:0] SCREEN_LIMIT      = 14'd8192;
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 14'd1024;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 14'd768;

    // register index, taken from paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_MARK_ALL = 2'd1,
        REQ_PRESENT  = 2'd2,
        REQ_RESERVED = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_REGION = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLIP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_INSERT,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [DIM_W-1:0]   out_width;
        logic [DIM_W-1:0]   out_height;
        logic [PEND_W-1:0]  pending_count;
        logic               last;
    } t_result_item;

    // effective screen size, already clamped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_screen;

    // stored region, 54 bits
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_entry;

    // candidate in edge form: left, top, right, bottom (exclusive)
    typedef struct packed {
        logic [DIM_W-1:0] l;
        logic [DIM_W-1:0] t;
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] b;
    } t_box;

    typedef struct packed {
        logic touch;
        t_box box;
    } t_merge;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        eff_dim = (v > SCREEN_LIMIT) ? SCREEN_LIMIT : v;
    endfunction

endpackage

// File: sv/drt_cfg.sv
// APB register file holding the screen size.
module drt_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drt_pkg::APB_AW-1:0]   paddr,
    input  logic [drt_pkg::APB_DW-1:0]   pwdata,
    output logic [drt_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output drt_pkg::t_screen             o_screen
);
    import drt_pkg::*;

    logic [DIM_W-1:0] r_sw;
    logic [DIM_W-1:0] r_sh;
    logic             w_wr;

    // low address bits ignored: two word registers
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SCREEN_WIDTH_RST;
            r_sh <= SCREEN_HEIGHT_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_SCREEN_HEIGHT) begin
                r_sh <= pwdata[DIM_W-1:0];
            end else begin
                r_sw <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SCREEN_WIDTH) begin
            prdata = {{(APB_DW-DIM_W){1'b0}}, r_sw};
        end else begin
            prdata = {{(APB_DW-DIM_W){1'b0}}, r_sh};
        end
    end

    assign o_screen.width  = eff_dim(r_sw);
    assign o_screen.height = eff_dim(r_sh);

endmodule

// File: sv/drt_cmp.sv
// Shared touch test and bounding-box merge of candidate against one entry.
module drt_cmp (
    input  drt_pkg::t_box   i_cand,
    input  drt_pkg::t_entry i_entry,
    output drt_pkg::t_merge o_merge
);
    import drt_pkg::*;

    logic [DIM_W-1:0] w_el;
    logic [DIM_W-1:0] w_et;
    logic [DIM_W-1:0] w_er;
    logic [DIM_W-1:0] w_eb;

    // entries stay inside the screen, so right/bottom fit 14 bits
    assign w_el = {1'b0, i_entry.x};
    assign w_et = {1'b0, i_entry.y};
    assign w_er = w_el + i_entry.w;
    assign w_eb = w_et + i_entry.h;

    // shared edges and corners count as touching
    assign o_merge.touch = (i_cand.l <= w_er) && (i_cand.r >= w_el) &&
                           (i_cand.t <= w_eb) && (i_cand.b >= w_et);

    assign o_merge.box.l = (i_cand.l < w_el) ? i_cand.l : w_el;
    assign o_merge.box.t = (i_cand.t < w_et) ? i_cand.t : w_et;
    assign o_merge.box.r = (i_cand.r > w_er) ? i_cand.r : w_er;
    assign o_merge.box.b = (i_cand.b > w_eb) ? i_cand.b : w_eb;

endmodule

// File: sv/drt_seq.sv
// Request sequencer with the region table, clipping and result register.
module drt_seq #(
    parameter int MAX_REGIONS = drt_pkg::MAX_REGIONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  drt_pkg::t_req_item    i_req,
    output logic                  o_busy,
    input  drt_pkg::t_screen      i_screen,
    output drt_pkg::t_box         o_cand,
    output drt_pkg::t_entry       o_entry,
    input  drt_pkg::t_merge       i_merge,
    output logic                  o_strobe,
    output drt_pkg::t_result_item o_result
);
    import drt_pkg::*;

    localparam int CNTW = $clog2(MAX_REGIONS + 1);
    localparam int AW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    t_state       r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic         r_wsd, n_wsd;
    logic [AW-1:0] r_idx, n_idx;
    t_box         r_cand, n_cand;
    t_req_item    r_req, n_req;
    t_entry       r_rdata;
    t_result_item r_out, n_out;
    logic         r_strobe, n_strobe;
    t_entry       r_mem [MAX_REGIONS];

    logic         w_accept;
    logic         w_idx_end;
    logic [CNTW-1:0] w_cm1;
    logic [AW-1:0] w_raddr;
    logic         w_we;
    logic [AW-1:0] w_waddr;
    t_entry       w_wdata;
    logic [PEND_W-1:0] w_pend_now;

    logic signed [17:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [17:0] w_x0c, w_y0c, w_x1c, w_y1c;
    logic signed [17:0] w_sw, w_sh;
    logic         w_clip_empty;
    t_box         w_clip;

    function automatic t_result_item make_result(
        input logic [1:0]         kind,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [DIM_W-1:0]   w,
        input logic [DIM_W-1:0]   h,
        input logic [PEND_W-1:0]  pend,
        input logic               last
    );
        t_result_item res;
        res.out_kind      = kind;
        res.out_x         = x;
        res.out_y         = y;
        res.out_width     = w;
        res.out_height    = h;
        res.pending_count = pend;
        res.last          = last;
        make_result = res;
    endfunction

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign o_busy     = (r_state != S_IDLE);
    assign w_idx_end  = ((CNTW'(r_idx) + 1'b1) == r_count);
    assign w_cm1      = r_count - 1'b1;
    assign w_pend_now = r_wsd ? PEND_W'(1) : PEND_W'(r_count);

    // clipping on the latched request
    assign w_x0  = {{2{r_req.rect_x[15]}}, r_req.rect_x};
    assign w_y0  = {{2{r_req.rect_y[15]}}, r_req.rect_y};
    assign w_x1  = w_x0 + $signed({2'b00, r_req.rect_width});
    assign w_y1  = w_y0 + $signed({2'b00, r_req.rect_height});
    assign w_sw  = $signed({4'b0000, i_screen.width});
    assign w_sh  = $signed({4'b0000, i_screen.height});
    assign w_x0c = w_x0[17] ? 18'sd0 : w_x0;
    assign w_y0c = w_y0[17] ? 18'sd0 : w_y0;
    assign w_x1c = (w_x1 > w_sw) ? w_sw : w_x1;
    assign w_y1c = (w_y1 > w_sh) ? w_sh : w_y1;
    assign w_clip_empty = (w_x1c <= w_x0c) || (w_y1c <= w_y0c);
    assign w_clip.l = w_x0c[DIM_W-1:0];
    assign w_clip.t = w_y0c[DIM_W-1:0];
    assign w_clip.r = w_x1c[DIM_W-1:0];
    assign w_clip.b = w_y1c[DIM_W-1:0];

    assign o_cand  = r_cand;
    assign o_entry = r_rdata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_ADD && !r_wsd) begin
                        n_state = S_CLIP;
                    end else if (i_req.req_type == REQ_PRESENT && !r_wsd &&
                                 r_count != '0) begin
                        n_state = S_DRAIN_RD;
                    end
                end
            end
            S_CLIP: begin
                if (w_clip_empty) begin
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_merge.touch) begin
                    n_state = S_MOVE_RD;
                end else if (w_idx_end) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_MOVE_RD:  n_state = S_MOVE_WR;
            S_MOVE_WR: begin
                n_state = (r_count == CNTW'(1)) ? S_INSERT : S_SCAN_RD;
            end
            S_INSERT:   n_state = S_IDLE;
            S_DRAIN_RD: n_state = S_DRAIN_OUT;
            S_DRAIN_OUT: begin
                n_state = w_idx_end ? S_IDLE : S_DRAIN_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_wsd    = r_wsd;
        n_idx    = r_idx;
        n_cand   = r_cand;
        n_req    = r_req;
        n_out    = '0;
        n_strobe = 1'b0;
        w_raddr  = r_idx;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req = i_req;
                    n_idx = '0;
                    case (i_req.req_type)
                        REQ_MARK_ALL: begin
                            n_wsd    = 1'b1;
                            n_count  = '0;
                            n_strobe = 1'b1;
                            n_out    = make_result(KIND_ACK, '0, '0, '0, '0,
                                                   PEND_W'(1), 1'b1);
                        end
                        REQ_PRESENT: begin
                            if (r_wsd) begin
                                n_wsd    = 1'b0;
                                n_count  = '0;
                                n_strobe = 1'b1;
                                n_out    = make_result(KIND_REGION, '0, '0,
                                                       i_screen.width,
                                                       i_screen.height,
                                                       '0, 1'b1);
                            end else if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_out    = make_result(KIND_NONE, '0, '0, '0,
                                                       '0, '0, 1'b1);
                            end
                        end
                        REQ_ADD: begin
                            if (r_wsd) begin
                                n_strobe = 1'b1;
                                n_out    = make_result(KIND_ACK, '0, '0, '0,
                                                       '0, w_pend_now, 1'b1);
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_out    = make_result(KIND_ACK, '0, '0, '0, '0,
                                                   w_pend_now, 1'b1);
                        end
                    endcase
                end
            end
            S_CLIP: begin
                if (w_clip_empty) begin
                    n_strobe = 1'b1;
                    n_out    = make_result(KIND_ACK, '0, '0, '0, '0,
                                           w_pend_now, 1'b1);
                end else begin
                    n_cand = w_clip;
                end
            end
            S_SCAN_RD: begin
                w_raddr = r_idx;
            end
            S_SCAN_CMP: begin
                if (i_merge.touch) begin
                    n_cand = i_merge.box;
                end else if (!w_idx_end) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MOVE_RD: begin
                // fetch the last entry to fill the merged slot
                w_raddr = w_cm1[AW-1:0];
            end
            S_MOVE_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_rdata;
                n_count = w_cm1;
                n_idx   = '0;
            end
            S_INSERT: begin
                n_strobe = 1'b1;
                if (r_count >= CNTW'(MAX_REGIONS)) begin
                    n_wsd   = 1'b1;
                    n_count = '0;
                    n_out   = make_result(KIND_ACK, '0, '0, '0, '0,
                                          PEND_W'(1), 1'b1);
                end else begin
                    w_we      = 1'b1;
                    w_waddr   = r_count[AW-1:0];
                    w_wdata.x = r_cand.l[COORD_W-1:0];
                    w_wdata.y = r_cand.t[COORD_W-1:0];
                    w_wdata.w = r_cand.r - r_cand.l;
                    w_wdata.h = r_cand.b - r_cand.t;
                    n_count   = r_count + 1'b1;
                    n_out     = make_result(KIND_ACK, '0, '0, '0, '0,
                                            PEND_W'(r_count + 1'b1), 1'b1);
                end
            end
            S_DRAIN_RD: begin
                w_raddr = r_idx;
            end
            S_DRAIN_OUT: begin
                n_strobe = 1'b1;
                n_out    = make_result(KIND_REGION, r_rdata.x, r_rdata.y,
                                       r_rdata.w, r_rdata.h, '0, w_idx_end);
                if (w_idx_end) begin
                    n_count = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_wsd    <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wsd    <= n_wsd;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_req  <= n_req;
        r_out  <= n_out;
    end

    // region table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: sv/damage_rect_tracker_top.sv
// Damage rectangle tracker: APB config, sequencer/table and shared merge unit.
// Mark-all, reserved, full-screen/empty present, ignored add: result next cycle.
// Add: clip, read and compare each entry; a merge moves the last entry into its slot
//   and rescans from entry 0; insert, result next. Present: read, output each region.
// Throughput: one transaction at a time; busy drops in the cycle of the final result.
// Results strobe one cycle, no stall. Sync active-low reset empties table and full-screen.
module damage_rect_tracker_top #(
    parameter int MAX_REGIONS = drt_pkg::MAX_REGIONS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  drt_pkg::t_req_item           i_req,
    // result channel
    output logic                         o_strobe,
    output drt_pkg::t_result_item        o_result,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drt_pkg::APB_AW-1:0]   paddr,
    input  logic [drt_pkg::APB_DW-1:0]   pwdata,
    output logic [drt_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import drt_pkg::*;

    t_screen w_screen;
    t_box    w_cand;
    t_entry  w_entry;
    t_merge  w_merge;

    // screen size registers, clamped to the supported limit
    drt_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_screen (w_screen)
    );

    // control sequencer, owns the region table and the result register
    drt_seq #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .o_busy   (busy),
        .i_screen (w_screen),
        .o_cand   (w_cand),
        .o_entry  (w_entry),
        .i_merge  (w_merge),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // one touch/merge unit reused for every entry visited by the scan
    drt_cmp u_cmp (
        .i_cand  (w_cand),
        .i_entry (w_entry),
        .o_merge (w_merge)
    );

    // every accepted transaction is either answered next cycle or keeps the block busy
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted transaction neither answered nor in progress");

    // a result that is not the last of its transaction leaves the block busy
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("block idle while a drain is unfinished");

    // drained regions and empty notices always report nothing pending
    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.out_kind == KIND_REGION ||
                      o_result.out_kind == KIND_NONE))
        |-> (o_result.pending_count == '0))
        else $error("present result with nonzero pending count");

endmodule

// File: tb/damage_rect_tracker_top_tb.sv
// Self-checking testbench of the damage rectangle tracker: directed table, then random phases.
`timescale 1ns / 100ps

module damage_rect_tracker_top_tb;
    import drt_pkg::*;

    // Generous cycle budget: even a worst-case add on each of the few hundred requests
    // would stay well inside it, so this is many times the slowest legal run.
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int N_DIRECTED   = 20;
    localparam int N_PHASES     = 7;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_req_item           i_req;
    logic                o_strobe;
    t_result_item        o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    damage_rect_tracker_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the tracker: screen registers, rectangle table, flags
    // ------------------------------------------------------------------
    typedef struct packed {
        int x;
        int y;
        int w;
        int h;
    } dmg_rect_t;

    typedef struct packed {
        t_req_item    rq;
        bit           typed;   // expected result typed in below, not predicted
        t_result_item res;
    } dir_row_t;

    logic [DIM_W-1:0] scr_w_reg;
    logic [DIM_W-1:0] scr_h_reg;
    dmg_rect_t        rect_tbl[MAX_REGIONS_DEF];
    int               rect_cnt;
    bit               whole_dirty;

    // results the tracker owes us, oldest first
    t_result_item     tracker_out_q[$];

    int mismatch_cnt;
    int cycle_cnt;
    int items_sent;
    int results_seen;
    int merge_cnt;
    int overflow_cnt;

    // stimulus generator memory
    int last_rx, last_ry, last_rw, last_rh;
    int grid_left, grid_k;

    // phase plan: screen size written before the phase, sender idle percentage, length
    int ph_w[N_PHASES]    = '{640, 16383, 8192, 1, 0, 200, 1024};
    int ph_h[N_PHASES]    = '{480, 16383, 1, 8192, 300, 150, 768};
    int ph_idle[N_PHASES] = '{0, 79, 24, 0, 24, 79, 0};
    int ph_len[N_PHASES]  = '{70, 70, 60, 50, 30, 60, 50};

    function automatic int clamp_screen(input logic [DIM_W-1:0] v);
        return (v > 14'd8192) ? 8192 : int'(v);
    endfunction

    function automatic int at_least_one(input int v);
        return (v < 1) ? 1 : v;
    endfunction

    function automatic t_req_item mk_req(input t_req_type op, input int x, input int y,
                                         input int w, input int h);
        t_req_item r;
        r.req_type    = op;
        r.rect_x      = x[15:0];
        r.rect_y      = y[15:0];
        r.rect_width  = w[15:0];
        r.rect_height = h[15:0];
        return r;
    endfunction

    function automatic t_result_item mk_result(input t_kind k, input int x, input int y,
                                               input int w, input int h, input int pend,
                                               input bit fin);
        t_result_item r;
        r.out_kind      = k;
        r.out_x         = x[COORD_W-1:0];
        r.out_y         = y[COORD_W-1:0];
        r.out_width     = w[DIM_W-1:0];
        r.out_height    = h[DIM_W-1:0];
        r.pending_count = pend[PEND_W-1:0];
        r.last          = fin;
        return r;
    endfunction

    // Apply one accepted request to the shadow state and queue the results it owes.
    function automatic void track_damage(input t_req_item rq);
        int        sw, sh, x0, y0, x1, y1, l, t, r, b, n, i;
        dmg_rect_t c, e;
        bit        merged;
        sw = clamp_screen(scr_w_reg);
        sh = clamp_screen(scr_h_reg);
        case (rq.req_type)
            REQ_MARK_ALL: begin
                whole_dirty = 1'b1;
                rect_cnt    = 0;
                tracker_out_q.push_back(mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1));
            end
            REQ_PRESENT: begin
                n        = rect_cnt;
                rect_cnt = 0;
                if (whole_dirty) begin
                    whole_dirty = 1'b0;
                    tracker_out_q.push_back(mk_result(KIND_REGION, 0, 0, sw, sh, 0, 1'b1));
                end else if (n == 0) begin
                    tracker_out_q.push_back(mk_result(KIND_NONE, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    for (i = 0; i < n; i++) begin
                        e = rect_tbl[i];
                        tracker_out_q.push_back(mk_result(KIND_REGION, e.x, e.y, e.w, e.h,
                                                          0, i == n - 1));
                    end
                end
            end
            default: begin
                // reserved code is acknowledged and otherwise ignored
                if (rq.req_type == REQ_ADD && !whole_dirty) begin
                    x0 = {{16{rq.rect_x[15]}}, rq.rect_x};
                    y0 = {{16{rq.rect_y[15]}}, rq.rect_y};
                    x1 = x0 + int'({16'b0, rq.rect_width});
                    y1 = y0 + int'({16'b0, rq.rect_height});
                    if (x0 < 0) x0 = 0;
                    if (y0 < 0) y0 = 0;
                    if (x1 > sw) x1 = sw;
                    if (y1 > sh) y1 = sh;
                    if (x1 > x0 && y1 > y0) begin
                        c = '{x0, y0, x1 - x0, y1 - y0};
                        // restart the scan after every merge; touching edges count
                        merged = 1'b1;
                        while (merged) begin
                            merged = 1'b0;
                            for (i = 0; i < rect_cnt; i++) begin
                                e = rect_tbl[i];
                                if (!merged && c.x <= e.x + e.w && c.x + c.w >= e.x &&
                                    c.y <= e.y + e.h && c.y + c.h >= e.y) begin
                                    l = (c.x < e.x) ? c.x : e.x;
                                    t = (c.y < e.y) ? c.y : e.y;
                                    r = (c.x + c.w > e.x + e.w) ? c.x + c.w : e.x + e.w;
                                    b = (c.y + c.h > e.y + e.h) ? c.y + c.h : e.y + e.h;
                                    c = '{l, t, r - l, b - t};
                                    rect_tbl[i] = rect_tbl[rect_cnt - 1];
                                    rect_cnt--;
                                    merged = 1'b1;
                                    merge_cnt++;
                                end
                            end
                        end
                        if (rect_cnt >= MAX_REGIONS_DEF) begin
                            whole_dirty = 1'b1;
                            rect_cnt    = 0;
                            overflow_cnt++;
                        end else begin
                            rect_tbl[rect_cnt] = c;
                            rect_cnt++;
                        end
                    end
                end
                tracker_out_q.push_back(mk_result(KIND_ACK, 0, 0, 0, 0,
                                                  whole_dirty ? 1 : rect_cnt, 1'b1));
            end
        endcase
    endfunction

    task automatic note_failure(input string msg);
        if (mismatch_cnt < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Random request source. Mostly adds: sparse small rectangles, rectangles that
    // touch the previous one at an edge or corner, and raw noise. Now and then a
    // grid burst of 16 to 20 disjoint adds can push the table into full-screen damage.
    // ------------------------------------------------------------------
    function automatic t_req_item next_request();
        t_req_item rq;
        int        sw, sh, pick, x, y, w, h, dx, dy, cw, ch;
        sw = at_least_one(clamp_screen(scr_w_reg));
        sh = at_least_one(clamp_screen(scr_h_reg));
        rq.req_type    = 2'($urandom_range(0, 3));
        rq.rect_x      = 16'($urandom_range(0, 65535));
        rq.rect_y      = 16'($urandom_range(0, 65535));
        rq.rect_width  = 16'($urandom_range(0, 65535));
        rq.rect_height = 16'($urandom_range(0, 65535));
        if (grid_left == 0 && $urandom_range(0, 99) < 4) begin
            grid_left = $urandom_range(17, 21);
            grid_k    = 0;
        end
        if (grid_left > 0) begin
            grid_left--;
            if (grid_left == 0) begin
                rq.req_type = REQ_PRESENT;
                return rq;
            end
            cw = sw / 5;
            ch = sh / 4;
            x  = (grid_k % 5) * cw + 1;
            y  = ((grid_k / 5) % 4) * ch + 1;
            grid_k++;
            return mk_req(REQ_ADD, x, y, at_least_one(cw - 3), at_least_one(ch - 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            rq.req_type = REQ_RESERVED;
            return rq;
        end
        if (pick < 9) begin
            rq.req_type = REQ_MARK_ALL;
            return rq;
        end
        if (pick < 19) begin
            rq.req_type = REQ_PRESENT;
            return rq;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            rq.req_type = REQ_ADD;
            return rq;
        end
        dx = $urandom_range(0, 2);
        dx = dx - 1;
        dy = $urandom_range(0, 2);
        dy = dy - 1;
        if (pick < 5) begin
            w = $urandom_range(1, at_least_one(sw / 8));
            h = $urandom_range(1, at_least_one(sh / 8));
            case ($urandom_range(0, 2))
                0: begin
                    x = last_rx + last_rw + dx;
                    y = last_ry + $urandom_range(0, at_least_one(last_rh));
                end
                1: begin
                    x = last_rx - w + dx;
                    y = last_ry + last_rh + dy;
                end
                default: begin
                    x = last_rx + last_rw + dx;
                    y = last_ry + last_rh + dy;
                end
            endcase
        end else begin
            w = $urandom_range(0, at_least_one(sw / 16));
            h = $urandom_range(0, at_least_one(sh / 16));
            x = $urandom_range(0, sw);
            y = $urandom_range(0, sh);
            x = x - 4;
            y = y - 4;
        end
        last_rx = x;
        last_ry = y;
        last_rw = w;
        last_rh = h;
        return mk_req(REQ_ADD, x, y, w, h);
    endfunction

    // ------------------------------------------------------------------
    // Request handshake: drive at the rising edge, look at busy mid-cycle (it only
    // moves on rising edges) and return at the edge that accepts the transaction.
    // ------------------------------------------------------------------
    task automatic issue_request(input t_req_item rq, input int gap);
        bit taken;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Wait until every owed result has come and the engine reports idle.
    task automatic wait_quiet();
        while (tracker_out_q.size() != 0) @(posedge i_clk);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input bit wr, input logic idx, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done  = pready;
            rdata = prdata;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_check(input logic idx, input logic [DIM_W-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== {{(APB_DW-DIM_W){1'b0}}, want})
            note_failure($sformatf("register %0d read %0h, expected %0h", idx, rd, want));
    endtask

    // Write a screen dimension (junk in the unused upper bits) and read it back.
    task automatic program_reg(input logic idx, input logic [DIM_W-1:0] value);
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] junk;
        junk = $urandom;
        apb_access(1'b1, idx, {junk[APB_DW-1:DIM_W], value}, rd);
        if (idx == REG_SCREEN_WIDTH)
            scr_w_reg = value;
        else
            scr_h_reg = value;
        read_check(idx, value);
    endtask

    // ------------------------------------------------------------------
    // Result checker: results cannot be held off, so every strobe is a transaction.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_result_item want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (tracker_out_q.size() == 0) begin
                note_failure($sformatf("unexpected result kind=%0d x=%0d y=%0d w=%0d h=%0d p=%0d l=%0b",
                             o_result.out_kind, o_result.out_x, o_result.out_y,
                             o_result.out_width, o_result.out_height,
                             o_result.pending_count, o_result.last));
            end else begin
                want = tracker_out_q.pop_front();
                if (o_result.out_kind !== want.out_kind || o_result.out_x !== want.out_x ||
                    o_result.out_y !== want.out_y || o_result.out_width !== want.out_width ||
                    o_result.out_height !== want.out_height ||
                    o_result.pending_count !== want.pending_count ||
                    o_result.last !== want.last)
                    note_failure($sformatf({"result mismatch: exp kind=%0d x=%0d y=%0d w=%0d ",
                                 "h=%0d p=%0d l=%0b, got kind=%0d x=%0d y=%0d w=%0d h=%0d ",
                                 "p=%0d l=%0b"},
                                 want.out_kind, want.out_x, want.out_y, want.out_width,
                                 want.out_height, want.pending_count, want.last,
                                 o_result.out_kind, o_result.out_x, o_result.out_y,
                                 o_result.out_width, o_result.out_height,
                                 o_result.pending_count, o_result.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, tracker_out_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t  dir_tab[N_DIRECTED];
        t_req_item rq;
        int        p, k, n0, gap;

        // every DUT input known from time zero
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        scr_w_reg    = SCREEN_WIDTH_RST;
        scr_h_reg    = SCREEN_HEIGHT_RST;
        rect_cnt     = 0;
        whole_dirty  = 1'b0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        items_sent   = 0;
        results_seen = 0;
        merge_cnt    = 0;
        overflow_cnt = 0;
        last_rx      = 100;
        last_ry      = 100;
        last_rw      = 10;
        last_rh      = 10;
        grid_left    = 0;
        grid_k       = 0;

        // Directed table, run at the reset screen size of 1024 x 768.
        // Typed rows: empty present, zero size, clipping extremes, full-screen mode.
        // Untyped rows: edge merge, bridging merge with rescan, corner touch.
        dir_tab[0]  = '{mk_req(REQ_PRESENT, 0, 0, 0, 0), 1'b1,
                        mk_result(KIND_NONE, 0, 0, 0, 0, 0, 1'b1)};
        dir_tab[1]  = '{mk_req(REQ_ADD, 0, 0, 0, 10), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b1)};
        dir_tab[2]  = '{mk_req(REQ_ADD, 5, 5, 5, 0), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b1)};
        dir_tab[3]  = '{mk_req(REQ_ADD, -32768, -32768, 65535, 65535), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[4]  = '{mk_req(REQ_PRESENT, 0, 0, 0, 0), 1'b1,
                        mk_result(KIND_REGION, 0, 0, 1024, 768, 0, 1'b1)};
        dir_tab[5]  = '{mk_req(REQ_ADD, 32767, 32767, 65535, 65535), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b1)};
        dir_tab[6]  = '{mk_req(REQ_ADD, 1023, 767, 1, 1), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[7]  = '{mk_req(REQ_ADD, 0, 0, 10, 10), 1'b0, '0};
        dir_tab[8]  = '{mk_req(REQ_ADD, 30, 0, 5, 5), 1'b0, '0};
        dir_tab[9]  = '{mk_req(REQ_ADD, 10, 0, 20, 3), 1'b0, '0};
        dir_tab[10] = '{mk_req(REQ_ADD, 35, 10, 4, 4), 1'b0, '0};
        dir_tab[11] = '{mk_req(REQ_ADD, -5, -5, 3, 3), 1'b0, '0};
        dir_tab[12] = '{mk_req(REQ_RESERVED, -1, -1, 65535, 65535), 1'b0, '0};
        dir_tab[13] = '{mk_req(REQ_PRESENT, 0, 0, 0, 0), 1'b0, '0};
        dir_tab[14] = '{mk_req(REQ_MARK_ALL, 0, 0, 0, 0), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[15] = '{mk_req(REQ_ADD, 5, 5, 5, 5), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[16] = '{mk_req(REQ_MARK_ALL, 7, 7, 7, 7), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[17] = '{mk_req(REQ_RESERVED, 0, 0, 0, 0), 1'b1,
                        mk_result(KIND_ACK, 0, 0, 0, 0, 1, 1'b1)};
        dir_tab[18] = '{mk_req(REQ_PRESENT, 0, 0, 0, 0), 1'b1,
                        mk_result(KIND_REGION, 0, 0, 1024, 768, 0, 1'b1)};
        dir_tab[19] = '{mk_req(REQ_PRESENT, -32768, 32767, 0, 65535), 1'b1,
                        mk_result(KIND_NONE, 0, 0, 0, 0, 0, 1'b1)};

        // synchronous reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers come out of reset at 1024 x 768
        read_check(REG_SCREEN_WIDTH, SCREEN_WIDTH_RST);
        read_check(REG_SCREEN_HEIGHT, SCREEN_HEIGHT_RST);

        for (k = 0; k < N_DIRECTED; k++) begin
            issue_request(dir_tab[k].rq, 0);
            n0 = tracker_out_q.size();
            track_damage(dir_tab[k].rq);
            if (dir_tab[k].typed) begin
                // shadow state still advances; the typed value replaces the prediction
                while (tracker_out_q.size() > n0) void'(tracker_out_q.pop_back());
                tracker_out_q.push_back(dir_tab[k].res);
            end
        end
        start <= 1'b0;
        wait_quiet();

        // Random phases. The screen size changes only while the engine is idle; the
        // table is left as it is, so stored entries survive a size change.
        for (p = 0; p < N_PHASES; p++) begin
            program_reg(REG_SCREEN_WIDTH, DIM_W'(ph_w[p]));
            program_reg(REG_SCREEN_HEIGHT, DIM_W'(ph_h[p]));
            for (k = 0; k < ph_len[p]; k++) begin
                rq  = next_request();
                gap = 0;
                if ($urandom_range(0, 99) < ph_idle[p])
                    gap = $urandom_range(1, 12);
                // halfway through each phase, hold off until everything has drained
                if (k == ph_len[p] / 2) begin
                    start <= 1'b0;
                    wait_quiet();
                end
                issue_request(rq, gap);
                track_damage(rq);
            end
            start <= 1'b0;
            wait_quiet();
        end

        // nothing owed any more; let any stray strobe show up
        repeat (20) @(posedge i_clk);

        if (tracker_out_q.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   tracker_out_q.size()));

        $display("Covered %0d requests and %0d results: %0d merges, %0d overflows to full screen.",
                 items_sent, results_seen, merge_cnt, overflow_cnt);
        $display("Screen sizes from 0 to 16383 per axis, sender idle at 0, 24 and 79 percent; %0d mismatches.",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
